// ===== rtl/sphere_capsule_contact_defines.svh =====
// Assertion macros for the sphere/capsule contact block.
`ifndef SPHERE_CAPSULE_CONTACT_DEFINES_SVH
`define SPHERE_CAPSULE_CONTACT_DEFINES_SVH
`ifndef ASSERT_OFF
`define SCC_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("scc: %s failed", "lbl");
`define SCC_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("scc: %s failed", "lbl");
`else
`define SCC_ASSERT_IMP(lbl, ante, cons)
`define SCC_ASSERT_NXT(lbl, ante, cons)
`endif
`endif

// ===== rtl/scc_pkg.sv =====
// Types and constants shared by the sphere/capsule contact block.
package scc_pkg;

	localparam int FRAC_BITS   = 16;
	localparam int AREA_SHIFT  = FRAC_BITS - 2;
	localparam int QUEUE_DEPTH = 2;

	localparam logic signed [31:0] ONE_Q30 = 32'sh4000_0000;
	localparam logic [31:0]        PI_Q30  = 32'd3373259426;

	typedef struct packed {
		logic signed [31:0] sphere_x;
		logic signed [31:0] sphere_y;
		logic signed [31:0] sphere_z;
		logic signed [31:0] capsule_x;
		logic signed [31:0] capsule_y;
		logic signed [31:0] capsule_z;
		logic signed [31:0] axis_x;
		logic signed [31:0] axis_y;
		logic signed [31:0] axis_z;
		logic [30:0]        sphere_radius;
		logic [30:0]        capsule_radius;
		logic [30:0]        capsule_height;
	} in_item_t;

	typedef struct packed {
		logic signed [32:0] impact_depth;
		logic [47:0]        overlap_area;
		logic signed [31:0] dir_x;
		logic signed [31:0] dir_y;
		logic signed [31:0] dir_z;
		logic signed [31:0] point_x;
		logic signed [31:0] point_y;
		logic signed [31:0] point_z;
		logic               in_contact;
		logic               new_contact;
	} out_item_t;

	// classified item handed from front to back
	typedef struct packed {
		logic [2:0][31:0] s;
		logic [2:0][33:0] u;
		logic [2:0]       neg;
		logic [63:0]      sq;
		logic             wide;
		logic [30:0]      rs;
		logic [30:0]      rc;
	} mid_t;

	typedef enum logic [2:0] {
		F_IDLE, F_DOT, F_CLAMP, F_PROJ, F_SQR, F_PUSH
	} front_state_t;

	typedef enum logic [3:0] {
		B_IDLE, B_SQRT, B_DEPTH, B_QMUL, B_QLOAD, B_QDIV, B_RSQ, B_SVSQ,
		B_DIFF, B_AHI, B_ALO, B_AREA, B_DIR, B_UDIV, B_PT, B_OUT
	} back_state_t;

endpackage

// ===== rtl/scc_front.sv =====
// Front end: axis projection, closest-point vector and squared length.
module scc_front (
	input  logic            clk,
	input  logic            arst_n,
	input  scc_pkg::in_item_t item,
	input  logic            item_valid,
	output logic            item_stall,
	output scc_pkg::mid_t   mid,
	output logic            mid_valid,
	input  logic            mid_full
);
	import scc_pkg::*;

	front_state_t st_q, st_d;
	logic [1:0]   idx_q;
	logic         ph_q;

	logic signed [31:0] s_q [3];
	logic signed [31:0] c_q [3];
	logic signed [31:0] a_q [3];
	logic [30:0]        rs_q, rc_q;
	logic [29:0]        hh_q;
	logic signed [66:0] acc_q;
	logic signed [31:0] dap_q;
	logic signed [34:0] v_q [3];
	logic [63:0]        sq_q;
	logic signed [65:0] prod_s1;

	logic signed [32:0] op_a, op_b;
	logic signed [65:0] prod_c;
	logic [33:0]        u_c [3];
	logic               wide_c;
	logic [31:0]        w_c;
	logic signed [66:0] dap_w, hh_w;
	logic signed [34:0] proj_c;
	logic               accept, last;

	function automatic logic signed [31:0] clamp_axis(logic signed [31:0] a);
		if (a > ONE_Q30)
			return ONE_Q30;
		else if (a < -ONE_Q30)
			return -ONE_Q30;
		return a;
	endfunction

	assign accept     = (st_q == F_IDLE) && item_valid;
	assign item_stall = (st_q != F_IDLE);
	assign last       = ph_q && (idx_q == 2'd2);

	always_comb begin
		for (int i = 0; i < 3; i++)
			u_c[i] = v_q[i][34] ? 34'(-v_q[i]) : v_q[i][33:0];
		wide_c = (u_c[0][33:31] != 3'd0) || (u_c[1][33:31] != 3'd0) ||
			(u_c[2][33:31] != 3'd0);
		w_c = wide_c ? u_c[idx_q][33:2] : u_c[idx_q][31:0];
	end

	always_comb begin
		op_a = '0;
		op_b = '0;
		case (st_q)
			F_DOT: begin
				op_a = $signed({s_q[idx_q][31], s_q[idx_q]}) -
					$signed({c_q[idx_q][31], c_q[idx_q]});
				op_b = $signed({a_q[idx_q][31], a_q[idx_q]});
			end
			F_PROJ: begin
				op_a = $signed({dap_q[31], dap_q});
				op_b = $signed({a_q[idx_q][31], a_q[idx_q]});
			end
			F_SQR: begin
				op_a = $signed({1'b0, w_c});
				op_b = $signed({1'b0, w_c});
			end
			default: ;
		endcase
	end

	assign prod_c = op_a * op_b;
	assign dap_w  = acc_q >>> 30;
	assign hh_w   = $signed({37'd0, hh_q});
	assign proj_c = 35'(prod_s1 >>> 30);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			st_q <= F_IDLE;
		else
			st_q <= st_d;
	end

	always_comb begin
		st_d = st_q;
		unique case (st_q)
			F_IDLE:  if (item_valid) st_d = F_DOT;
			F_DOT:   if (last) st_d = F_CLAMP;
			F_CLAMP: st_d = F_PROJ;
			F_PROJ:  if (last) st_d = F_SQR;
			F_SQR:   if (last) st_d = F_PUSH;
			F_PUSH:  if (!mid_full) st_d = F_IDLE;
			default: st_d = F_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= '0;
			ph_q  <= 1'b0;
		end else if (st_q == F_DOT || st_q == F_PROJ || st_q == F_SQR) begin
			ph_q <= ~ph_q;
			if (ph_q)
				idx_q <= (idx_q == 2'd2) ? 2'd0 : idx_q + 2'd1;
		end else begin
			idx_q <= '0;
			ph_q  <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		prod_s1 <= prod_c;
		if (accept) begin
			s_q[0] <= item.sphere_x;
			s_q[1] <= item.sphere_y;
			s_q[2] <= item.sphere_z;
			c_q[0] <= item.capsule_x;
			c_q[1] <= item.capsule_y;
			c_q[2] <= item.capsule_z;
			a_q[0] <= clamp_axis(item.axis_x);
			a_q[1] <= clamp_axis(item.axis_y);
			a_q[2] <= clamp_axis(item.axis_z);
			rs_q   <= item.sphere_radius;
			rc_q   <= item.capsule_radius;
			hh_q   <= item.capsule_height[30:1];
			acc_q  <= '0;
			sq_q   <= '0;
		end
		if (st_q == F_DOT && ph_q)
			acc_q <= acc_q + {prod_s1[65], prod_s1};
		if (st_q == F_CLAMP) begin
			if (dap_w > hh_w)
				dap_q <= $signed({2'b00, hh_q});
			else if (dap_w < -hh_w)
				dap_q <= -$signed({2'b00, hh_q});
			else
				dap_q <= dap_w[31:0];
		end
		if (st_q == F_PROJ && ph_q)
			v_q[idx_q] <= $signed({{3{c_q[idx_q][31]}}, c_q[idx_q]}) + proj_c -
				$signed({{3{s_q[idx_q][31]}}, s_q[idx_q]});
		if (st_q == F_SQR && ph_q)
			sq_q <= sq_q + prod_s1[63:0];
	end

	assign mid_valid = (st_q == F_PUSH);

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			mid.s[i]   = s_q[i];
			mid.u[i]   = u_c[i];
			mid.neg[i] = v_q[i][34];
		end
		mid.sq   = sq_q;
		mid.wide = wide_c;
		mid.rs   = rs_q;
		mid.rc   = rc_q;
	end

endmodule

// ===== rtl/scc_queue.sv =====
// Small register queue between front and back.
module scc_queue (
	input  logic          clk,
	input  logic          arst_n,
	input  scc_pkg::mid_t wdata,
	input  logic          push,
	output logic          full,
	output scc_pkg::mid_t rdata,
	output logic          nonempty,
	input  logic          pop
);
	import scc_pkg::*;

	localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

	mid_t          mem_q [QUEUE_DEPTH];
	logic [PW-1:0] wp_q, rp_q;
	logic [PW:0]   cnt_q;
	logic          do_push, do_pop;

	assign full     = (cnt_q == (PW+1)'(QUEUE_DEPTH));
	assign nonempty = (cnt_q != '0);
	assign do_push  = push && !full;
	assign do_pop   = pop && nonempty;
	assign rdata    = mem_q[rp_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push)
				wp_q <= (wp_q == PW'(QUEUE_DEPTH - 1)) ? '0 : wp_q + 1'b1;
			if (do_pop)
				rp_q <= (rp_q == PW'(QUEUE_DEPTH - 1)) ? '0 : rp_q + 1'b1;
			if (do_push && !do_pop)
				cnt_q <= cnt_q + 1'b1;
			else if (do_pop && !do_push)
				cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (do_push)
			mem_q[wp_q] <= wdata;
	end

endmodule

// ===== rtl/scc_back.sv =====
// Back end: square root, depth, overlap area, direction and impact point.
module scc_back (
	input  logic              clk,
	input  logic              arst_n,
	input  scc_pkg::mid_t     mid,
	input  logic              mid_valid,
	output logic              mid_pop,
	output scc_pkg::out_item_t res,
	output logic              res_valid,
	input  logic              res_stall
);
	import scc_pkg::*;

	localparam logic signed [35:0] DEPTH_MIN = -36'sd4294967296;
	localparam logic [30:0]        MAG_ONE   = 31'h4000_0000;

	back_state_t st_q, st_d;
	logic [4:0]  cnt_q;
	logic [1:0]  idx_q;
	logic        ph_q;

	logic signed [31:0] s_q [3];
	logic [33:0]        u_q [3];
	logic [2:0]         neg_q;
	logic               wide_q;
	logic [30:0]        rs_q, rc_q;

	logic [63:0] x_q;
	logic [33:0] rem_q;
	logic [31:0] root_q;

	logic [33:0]        dist_q;
	logic signed [35:0] depth_q;
	logic               contact_q;

	logic [34:0] drem_q;
	logic [30:0] dnum_q, dquo_q;
	logic [33:0] dden_q;

	logic signed [32:0] sv_q;
	logic [63:0]        rsq_q, ahi_q;
	logic signed [63:0] diff_q;
	logic [47:0]        area_q;
	logic signed [31:0] dir_q [3];
	logic signed [38:0] thd_q;
	logic signed [31:0] pt_q [3];
	logic signed [65:0] prod_s1;

	out_item_t res_q;
	logic      res_valid_q, active_q;

	logic signed [32:0] op_a, op_b;
	logic signed [65:0] prod_c;
	logic [35:0]        rt_c;
	logic [33:0]        trial_c;
	logic               sq_ge;
	logic [35:0]        dt_c;
	logic               d_ge;
	logic [34:0]        drem_c;
	logic [30:0]        dquo_c;
	logic [33:0]        dist_c;
	logic signed [35:0] depth_c;
	logic signed [63:0] diff_c;
	logic [33:0]        u_c;
	logic               u_cap, u_ge, dir_zero;
	logic [30:0]        mag_c;
	logic signed [36:0] t_c;
	logic signed [6:0]  th_c;
	logic [29:0]        tl_c;
	logic signed [38:0] thd_c;
	logic [63:0]        asum_c, ash_c;
	logic signed [39:0] pt_c;
	logic               out_load, last_pt;

	// sqrt step
	assign rt_c    = {rem_q, x_q[63:62]};
	assign trial_c = {root_q, 2'b01};
	assign sq_ge   = rt_c >= {2'b00, trial_c};

	// shared restoring divider step
	assign dt_c   = {drem_q, dnum_q[30]};
	assign d_ge   = dt_c >= {2'b00, dden_q};
	assign drem_c = d_ge ? 35'(dt_c - {2'b00, dden_q}) : dt_c[34:0];
	assign dquo_c = {dquo_q[29:0], d_ge};

	assign dist_c  = wide_q ? {root_q, 2'b00} : {2'b00, root_q};
	assign depth_c = $signed({5'd0, rs_q}) + $signed({5'd0, rc_q}) -
		$signed({2'b00, dist_c});
	assign diff_c  = $signed(rsq_q) - prod_s1[63:0];

	assign u_c      = u_q[idx_q];
	assign dir_zero = (dist_q == '0);
	assign u_cap    = {1'b0, u_c} >= {dist_q, 1'b0};
	assign u_ge     = u_c >= dist_q;
	assign mag_c    = (st_q == B_UDIV) ?
		((dquo_c > MAG_ONE) ? MAG_ONE : dquo_c) : MAG_ONE;

	assign t_c   = $signed({6'd0, rs_q}) - (($signed({depth_q[35], depth_q})) >>> 1);
	assign th_c  = t_c[36:30];
	assign tl_c  = t_c[29:0];
	assign thd_c = th_c * dir_q[idx_q];

	assign asum_c = ahi_q + (prod_s1[63:0] >> 32);
	assign ash_c  = asum_c >> AREA_SHIFT;

	assign pt_c = $signed({{8{s_q[idx_q][31]}}, s_q[idx_q]}) + 40'(thd_q) +
		40'(prod_s1 >>> 30);

	always_comb begin
		op_a = '0;
		op_b = '0;
		case (st_q)
			B_QMUL: begin
				op_a = $signed({1'b0, depth_q[31:0]});
				op_b = $signed({2'b00, rc_q});
			end
			B_RSQ: begin
				op_a = $signed({2'b00, rs_q});
				op_b = $signed({2'b00, rs_q});
			end
			B_SVSQ: begin
				op_a = sv_q;
				op_b = sv_q;
			end
			B_AHI: begin
				op_a = $signed({3'b000, diff_q[61:32]});
				op_b = $signed({1'b0, PI_Q30});
			end
			B_ALO: begin
				op_a = $signed({1'b0, diff_q[31:0]});
				op_b = $signed({1'b0, PI_Q30});
			end
			B_PT: begin
				op_a = $signed({3'b000, tl_c});
				op_b = $signed({dir_q[idx_q][31], dir_q[idx_q]});
			end
			default: ;
		endcase
	end

	assign prod_c   = op_a * op_b;
	assign out_load = (st_q == B_OUT) && (!res_valid_q || !res_stall);
	assign mid_pop  = (st_q == B_IDLE) && mid_valid;
	assign last_pt  = ph_q && (idx_q == 2'd2);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			st_q <= B_IDLE;
		else
			st_q <= st_d;
	end

	always_comb begin
		st_d = st_q;
		unique case (st_q)
			B_IDLE:  if (mid_valid) st_d = B_SQRT;
			B_SQRT:  if (cnt_q == '0) st_d = B_DEPTH;
			B_DEPTH: st_d = (depth_c > 0) ? B_QMUL : B_DIR;
			B_QMUL:  st_d = B_QLOAD;
			B_QLOAD: st_d = B_QDIV;
			B_QDIV:  if (cnt_q == '0) st_d = B_RSQ;
			B_RSQ:   st_d = B_SVSQ;
			B_SVSQ:  st_d = B_DIFF;
			B_DIFF:  st_d = (diff_c > 0) ? B_AHI : B_DIR;
			B_AHI:   st_d = B_ALO;
			B_ALO:   st_d = B_AREA;
			B_AREA:  st_d = B_DIR;
			B_DIR: begin
				if (!dir_zero && !u_cap)
					st_d = B_UDIV;
				else if (idx_q == 2'd2)
					st_d = B_PT;
			end
			B_UDIV: begin
				if (cnt_q == '0)
					st_d = (idx_q == 2'd2) ? B_PT : B_DIR;
			end
			B_PT:    if (last_pt) st_d = B_OUT;
			B_OUT:   if (out_load) st_d = B_IDLE;
			default: st_d = B_IDLE;
		endcase
	end

	// counters and lane index
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			idx_q <= '0;
			ph_q  <= 1'b0;
		end else begin
			case (st_q)
				B_IDLE: begin
					cnt_q <= 5'd31;
					idx_q <= '0;
					ph_q  <= 1'b0;
				end
				B_SQRT, B_QDIV, B_UDIV: begin
					cnt_q <= cnt_q - 5'd1;
					if (st_q == B_UDIV && cnt_q == '0)
						idx_q <= (idx_q == 2'd2) ? 2'd0 : idx_q + 2'd1;
				end
				B_QLOAD: cnt_q <= 5'd30;
				B_DIR: begin
					if (!dir_zero && !u_cap)
						cnt_q <= 5'd29;
					else
						idx_q <= (idx_q == 2'd2) ? 2'd0 : idx_q + 2'd1;
				end
				B_PT: begin
					ph_q <= ~ph_q;
					if (ph_q)
						idx_q <= (idx_q == 2'd2) ? 2'd0 : idx_q + 2'd1;
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		prod_s1 <= prod_c;
		case (st_q)
			B_IDLE: begin
				for (int i = 0; i < 3; i++) begin
					s_q[i] <= mid.s[i];
					u_q[i] <= mid.u[i];
				end
				neg_q  <= mid.neg;
				wide_q <= mid.wide;
				rs_q   <= mid.rs;
				rc_q   <= mid.rc;
				x_q    <= mid.sq;
				rem_q  <= '0;
				root_q <= '0;
			end
			B_SQRT: begin
				x_q    <= {x_q[61:0], 2'b00};
				rem_q  <= sq_ge ? 34'(rt_c - {2'b00, trial_c}) : rt_c[33:0];
				root_q <= {root_q[30:0], sq_ge};
			end
			B_DEPTH: begin
				dist_q    <= dist_c;
				depth_q   <= depth_c;
				contact_q <= depth_c > 0;
				area_q    <= '0;
			end
			B_QLOAD: begin
				drem_q <= {3'b000, prod_s1[62:31]};
				dnum_q <= prod_s1[30:0];
				dquo_q <= '0;
				dden_q <= {2'b00, 32'({1'b0, rs_q} + {1'b0, rc_q})};
			end
			B_QDIV, B_UDIV: begin
				drem_q <= drem_c;
				dnum_q <= {dnum_q[29:0], 1'b0};
				dquo_q <= dquo_c;
				if (st_q == B_QDIV && cnt_q == '0)
					sv_q <= $signed({2'b00, rs_q}) - $signed({2'b00, dquo_c});
				if (st_q == B_UDIV && cnt_q == '0)
					dir_q[idx_q] <= neg_q[idx_q] ? -$signed({1'b0, mag_c}) :
						$signed({1'b0, mag_c});
			end
			B_SVSQ: rsq_q <= prod_s1[63:0];
			B_DIFF: diff_q <= diff_c;
			B_ALO:  ahi_q <= prod_s1[63:0];
			B_AREA: area_q <= (ash_c[63:48] != '0) ? '1 : ash_c[47:0];
			B_DIR: begin
				if (dir_zero)
					dir_q[idx_q] <= '0;
				else if (u_cap)
					dir_q[idx_q] <= neg_q[idx_q] ? -$signed({1'b0, mag_c}) :
						$signed({1'b0, mag_c});
				else begin
					drem_q <= {1'b0, u_ge ? u_c - dist_q : u_c};
					dnum_q <= '0;
					dquo_q <= {30'd0, u_ge};
					dden_q <= dist_q;
				end
			end
			B_PT: begin
				if (!ph_q)
					thd_q <= thd_c;
				else if (pt_c > 40'sd2147483647)
					pt_q[idx_q] <= 32'sh7fff_ffff;
				else if (pt_c < -40'sd2147483648)
					pt_q[idx_q] <= 32'sh8000_0000;
				else
					pt_q[idx_q] <= pt_c[31:0];
			end
			default: ;
		endcase
		if (out_load) begin
			res_q.impact_depth <= (depth_q < DEPTH_MIN) ? DEPTH_MIN[32:0] : depth_q[32:0];
			res_q.overlap_area <= area_q;
			res_q.dir_x        <= dir_q[0];
			res_q.dir_y        <= dir_q[1];
			res_q.dir_z        <= dir_q[2];
			res_q.point_x      <= pt_q[0];
			res_q.point_y      <= pt_q[1];
			res_q.point_z      <= pt_q[2];
			res_q.in_contact   <= contact_q;
			res_q.new_contact  <= contact_q && !active_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
			active_q    <= 1'b0;
		end else begin
			if (out_load) begin
				res_valid_q <= 1'b1;
				active_q    <= contact_q;
			end else if (!res_stall)
				res_valid_q <= 1'b0;
		end
	end

	assign res       = res_q;
	assign res_valid = res_valid_q;

endmodule

// ===== rtl/sphere_capsule_contact.sv =====
// Sphere versus capsule contact detector, top level.
// Input channel: item / item_valid / item_stall. One item holds a sphere
// center, a capsule center, the capsule unit axis (Q2.30), both radii and
// the capsule height (Q16.16). Result channel: res / res_valid / res_stall,
// one result per item with depth, overlap area, unit direction, impact point,
// in_contact and new_contact.
// The front projects and builds the closest-point vector and its squared length;
// a two-entry queue lets it take the next item while the back works.
// The back runs a 32-step square root, a 31-step divide for the area term and
// up to three 30-step divides for the direction, then three point updates.
// Reset clears both state machines, the queue and the stored contact bit.
// While res_stall is high the result holds and the back waits; the front
// keeps taking items until the queue fills; item_stall is high while it is busy.
`include "sphere_capsule_contact_defines.svh"

module sphere_capsule_contact (
	input  logic               clk,
	input  logic               arst_n,
	input  scc_pkg::in_item_t  item,
	input  logic               item_valid,
	output logic               item_stall,
	output scc_pkg::out_item_t res,
	output logic               res_valid,
	input  logic               res_stall
);
	import scc_pkg::*;

	mid_t f_mid, q_mid;
	logic f_valid, q_full, q_nonempty, b_pop;

	scc_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.item       (item),
		.item_valid (item_valid),
		.item_stall (item_stall),
		.mid        (f_mid),
		.mid_valid  (f_valid),
		.mid_full   (q_full)
	);

	scc_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.wdata    (f_mid),
		.push     (f_valid),
		.full     (q_full),
		.rdata    (q_mid),
		.nonempty (q_nonempty),
		.pop      (b_pop)
	);

	scc_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.mid       (q_mid),
		.mid_valid (q_nonempty),
		.mid_pop   (b_pop),
		.res       (res),
		.res_valid (res_valid),
		.res_stall (res_stall)
	);

	`SCC_ASSERT_IMP(a_new_needs_contact, res_valid, !res.new_contact || res.in_contact)
	`SCC_ASSERT_IMP(a_area_zero_apart, res_valid && !res.in_contact, res.overlap_area == 48'd0)
	`SCC_ASSERT_IMP(a_contact_is_depth, res_valid, res.in_contact == (!res.impact_depth[32] && res.impact_depth != 33'd0))
	`SCC_ASSERT_NXT(a_front_busy, item_valid && !item_stall, item_stall)

endmodule
